// ===== hw/rtl/lec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lec_pkg
// Shared types and constants of the line ending converter: character codes,
// the run of output bytes produced by one input item, and register decode.
// ----------------------------------------------------------------------------
package lec_pkg;

  // character codes
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // longest run of output bytes caused by one input item
  localparam int RUN_MAX   = 4;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

  // register port: one 32-bit register, byte addressed
  localparam int              ADDR_W           = 3;
  localparam int              DATA_W           = 32;
  localparam logic [ADDR_W-1:0] REG_WINDOWS_MODE = 3'd0;

  // output bytes of one item, byte 0 leaves first
  typedef struct packed {
    logic [RUN_CNT_W-1:0]     cnt;
    logic [RUN_MAX-1:0][7:0]  bytes;
  } run_t;

endpackage

// ===== hw/rtl/lec_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lec_core
// Lookbehind stage: holds the previous byte and builds the run of output
// bytes for the incoming item from the held byte, the new byte and the mode.
// ----------------------------------------------------------------------------
module lec_core
  import lec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  input  logic       windows_mode,
  output run_t       run
);

  logic [7:0] held_byte;
  logic       held_valid;
  logic [7:0] held_byte_next;
  logic       held_valid_next;

  // run and next lookbehind state for the current item
  always_comb begin
    run             = '0;
    held_byte_next  = data_byte;
    held_valid_next = 1'b1;
    if (end_of_stream) begin
      held_byte_next  = '0;
      held_valid_next = 1'b0;
      if (held_valid) begin
        if (windows_mode && held_byte == CH_LF) begin
          run.cnt      = RUN_CNT_W'(2);
          run.bytes[0] = CH_CR;
          run.bytes[1] = CH_LF;
        end else begin
          run.cnt      = RUN_CNT_W'(1);
          run.bytes[0] = held_byte;
        end
      end
    end else if (!held_valid) begin
      run.cnt = '0;
    end else if (windows_mode) begin
      if (data_byte == CH_LF) begin
        // line ending completes, nothing held afterwards
        held_byte_next  = '0;
        held_valid_next = 1'b0;
        if (held_byte == CH_CR) begin
          run.cnt      = RUN_CNT_W'(2);
          run.bytes[0] = CH_CR;
          run.bytes[1] = CH_LF;
        end else if (held_byte == CH_LF) begin
          run.cnt      = RUN_CNT_W'(4);
          run.bytes[0] = CH_CR;
          run.bytes[1] = CH_LF;
          run.bytes[2] = CH_CR;
          run.bytes[3] = CH_LF;
        end else begin
          run.cnt      = RUN_CNT_W'(3);
          run.bytes[0] = held_byte;
          run.bytes[1] = CH_CR;
          run.bytes[2] = CH_LF;
        end
      end else if (held_byte == CH_LF) begin
        run.cnt      = RUN_CNT_W'(2);
        run.bytes[0] = CH_CR;
        run.bytes[1] = CH_LF;
      end else begin
        run.cnt      = RUN_CNT_W'(1);
        run.bytes[0] = held_byte;
      end
    end else begin
      // unix mode: cr directly before lf is dropped
      if (!(held_byte == CH_CR && data_byte == CH_LF)) begin
        run.cnt      = RUN_CNT_W'(1);
        run.bytes[0] = held_byte;
      end
    end
  end

  // lookbehind register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte  <= '0;
      held_valid <= 1'b0;
    end else if (accept) begin
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
    end
  end

endmodule

// ===== hw/rtl/lec_drain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lec_drain
// Result register: takes a whole run at once and hands it out one byte per
// cycle while the output is not stalled, marking the final byte of the run.
// ----------------------------------------------------------------------------
module lec_drain
  import lec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  run_t       run,
  output logic       load_ok,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_in_run
);

  logic [RUN_CNT_W-1:0]    cnt;
  logic [RUN_MAX-1:0][7:0] bytes;
  logic                    pop;

  assign out_valid   = (cnt != '0);
  assign out_byte    = bytes[0];
  assign last_in_run = (cnt == RUN_CNT_W'(1));
  assign pop         = out_valid && !out_stall;

  // a new run fits when the buffer is empty or its last byte leaves now
  assign load_ok = (cnt == '0) || (last_in_run && !out_stall);

  // byte count, control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= run.cnt;
    end else if (pop) begin
      cnt <= cnt - RUN_CNT_W'(1);
    end
  end

  // run bytes, shifted toward byte 0 as they leave
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= run.bytes;
    end else if (pop) begin
      bytes <= bytes >> 8;
    end
  end

endmodule

// ===== hw/rtl/line_ending_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_ending_converter_unit
// Byte stream line ending converter with one byte of lookbehind, converting
// to lf or cr lf endings as selected by the windows_mode register.
//
//   channel  signals                                   direction
//   in       in_valid, in_stall, data_byte,            into the block
//            end_of_stream
//   out      out_valid, out_stall, out_byte,           out of the block
//            last_in_run
//   cfg      psel, penable, pwrite, paddr, pwdata,     register port
//            prdata, pready
//
// Each accepted item's 0 to 4 output bytes leave one per cycle from the
// result register while the output is not stalled; the next item is taken
// as the last of them leaves, set by the single output byte lane. An item
// with at most one byte flows at one item per cycle while out_stall is low.
// Synchronous reset clears the held byte, the result register's byte count and the mode.
// A stalled output keeps its byte and holds off the input until the last
// byte of its run leaves.
// ----------------------------------------------------------------------------
module line_ending_converter_unit
  import lec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input transactions
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  // output transactions
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              last_in_run,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic windows_mode;
  logic in_accept;
  logic load_ok;
  run_t run;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      windows_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == 1'b0) begin
      windows_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1] == REG_WINDOWS_MODE[ADDR_W-1]) begin
      prdata[0] = windows_mode;
    end
  end

  // input handshake
  assign in_stall  = !load_ok;
  assign in_accept = in_valid && !in_stall;

  lec_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .windows_mode  (windows_mode),
    .run           (run)
  );

  lec_drain u_drain (
    .clk         (clk),
    .rst         (rst),
    .load        (in_accept),
    .run         (run),
    .load_ok     (load_ok),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_in_run (last_in_run)
  );

`ifndef SYNTHESIS
  // input is never held off while nothing waits at the output
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // end of stream never produces more than two bytes
  a_eos_run: assert property (@(posedge clk) disable iff (rst)
    in_accept && end_of_stream |-> run.cnt <= RUN_CNT_W'(2))
    else $error("end of stream run too long");

  // a run keeps going until its marked byte leaves
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_in_run |=> out_valid)
    else $error("run ended without last byte");

  // an accepted item with output shows a byte next cycle
  a_run_shown: assert property (@(posedge clk) disable iff (rst)
    in_accept && run.cnt != '0 |=> out_valid)
    else $error("accepted run not presented");
`endif

endmodule

// ===== test/line_ending_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_ending_converter_unit_tb
// Self-checking bench for the line ending converter. A scoreboard object
// keeps its own copy of the held byte and the mode, expands every accepted
// input transaction into the bytes the block must emit, and compares each
// output transaction in order. Stimulus is a short directed pass over the
// line ending cases in both modes, then random text lines with mixed endings
// and noise, with the mode register rewritten between phases. The sender
// idles in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module line_ending_converter_unit_tb;
  import lec_pkg::*;

  // address with no register behind it, writes there must not land
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
  localparam int                RAND_PHASES   = 8;
  localparam int                PHASE_ITEMS   = 48;
  localparam int                DRAIN_CYCLES  = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
  } out_beat_t;

  // expected output bytes of the converter, predicted per input transaction
  class line_ending_scoreboard;
    logic        windows_mode;
    logic [7:0]  held_byte;
    logic        held_valid;
    out_beat_t   expected_bytes[$];
    int          errors;

    function new();
      windows_mode = 1'b0;
      held_byte    = 8'h00;
      held_valid   = 1'b0;
      errors       = 0;
    endfunction

    // expand one accepted input into its run of output bytes
    function void take_input(logic [7:0] c, logic eos);
      logic [7:0] run_bytes[$];
      out_beat_t  beat;
      if (eos) begin
        if (held_valid) begin
          if (windows_mode && held_byte == CH_LF) run_bytes.push_back(CH_CR);
          run_bytes.push_back(held_byte);
        end
        held_byte  = 8'h00;
        held_valid = 1'b0;
      end else if (!held_valid) begin
        held_byte  = c;
        held_valid = 1'b1;
      end else if (windows_mode) begin
        if (c == CH_LF) begin
          // a complete ending goes out at once, nothing stays held
          if (held_byte == CH_LF) begin
            run_bytes.push_back(CH_CR);
            run_bytes.push_back(CH_LF);
          end else if (held_byte != CH_CR) begin
            run_bytes.push_back(held_byte);
          end
          run_bytes.push_back(CH_CR);
          run_bytes.push_back(CH_LF);
          held_byte  = 8'h00;
          held_valid = 1'b0;
        end else begin
          if (held_byte == CH_LF) run_bytes.push_back(CH_CR);
          run_bytes.push_back(held_byte);
          held_byte = c;
        end
      end else begin
        // cr directly before lf is dropped
        if (!(held_byte == CH_CR && c == CH_LF)) run_bytes.push_back(held_byte);
        held_byte = c;
      end
      foreach (run_bytes[i]) begin
        beat.out_byte    = run_bytes[i];
        beat.last_in_run = (i == run_bytes.size() - 1);
        expected_bytes.push_back(beat);
      end
    endfunction

    // compare one output transaction with the oldest expected byte
    function void check_output(logic [7:0] b, logic last);
      out_beat_t want;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: unexpected transaction, actual %h last_in_run %b", b, last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (b !== want.out_byte) begin
        $error("out_byte mismatch: expected %h, actual %h", want.out_byte, b);
        errors++;
      end
      if (last !== want.last_in_run) begin
        $error("last_in_run mismatch: expected %b, actual %b", want.last_in_run, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [7:0]        data_byte     = 8'h00;
  logic              end_of_stream = 1'b0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [7:0]        out_byte;
  logic              last_in_run;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  line_ending_scoreboard sb = new();

  int burst_left  = 0;
  int stall_style = 0;
  int style_left  = 0;

  line_ending_converter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_in_run   (last_in_run),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // receiver stall pattern, style changes every so often
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(20, 200);
    end else begin
      style_left--;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // note accepted inputs before checking outputs of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_input(data_byte, end_of_stream);
      if (out_valid && !out_stall) sb.check_output(out_byte, last_in_run);
    end
  end

  // one input transaction, with burst gaps between groups
  task automatic send_item(input logic [7:0] b, input logic eos);
    if (burst_left == 0) begin
      in_valid  <= 1'b0;
      data_byte <= 8'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // register write followed by a readback of the mode
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == REG_WINDOWS_MODE) sb.windows_mode = value[0];
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= REG_WINDOWS_MODE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(DATA_W-1){1'b0}}, sb.windows_mode}) begin
      $error("windows_mode readback mismatch: expected %h, actual %h",
             sb.windows_mode, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // block is idle once every expected byte is out and the pipe has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random text line: content bytes, then one of several endings
  task automatic send_line(inout int sent);
    int         len;
    logic [7:0] b;
    len = $urandom_range(0, 6);
    repeat (len) begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(8'h20, 8'h7e));
      send_item(b, 1'b0);
      sent++;
    end
    case ($urandom_range(0, 7))
      0, 1: begin
        send_item(CH_LF, 1'b0);
        sent++;
      end
      2, 3: begin
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        sent += 2;
      end
      4: begin
        send_item(CH_CR, 1'b0);
        sent++;
      end
      5: begin
        send_item(CH_LF, 1'b0);
        send_item(CH_LF, 1'b0);
        sent += 2;
      end
      6: begin
        send_item(CH_CR, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        sent += 3;
      end
      default: begin
        // noise: loose cr, lf and arbitrary bytes
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: b = CH_CR;
            1: b = CH_LF;
            default: b = 8'($urandom_range(0, 255));
          endcase
          send_item(b, 1'b0);
          sent++;
        end
      end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      send_item(8'($urandom), 1'b1);
      sent++;
    end
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int sent;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unix mode, upper data bits set, and a write that must not land
    write_reg(REG_WINDOWS_MODE, 32'hFFFF_FFFE);
    write_reg(UNMAPPED_ADDR, 32'h0000_0001);

    // unix directed: empty flush, extremes, cr lf, lone cr, flush
    send_item(8'($urandom), 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(8'($urandom), 1'b1);
    wait_idle();

    // windows directed: lf lf, cr lf, byte lf, lf then byte, lone cr, flushes
    write_reg(REG_WINDOWS_MODE, 32'h0000_0001);
    send_item(CH_LF, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(8'h79, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(8'h7A, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(8'($urandom), 1'b1);
    send_item(CH_CR, 1'b0);
    send_item(8'($urandom), 1'b1);
    wait_idle();

    // random phases, mode alternates with random upper data bits
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(REG_WINDOWS_MODE, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'(p % 2)});
      sent = 0;
      while (sent < PHASE_ITEMS) send_line(sent);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
